// File: hdl/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg: shared types and codes of the positional list
// Command and status codes, and the per-cycle control handed to every cell.
// ----------------------------------------------------------------------------
package pidl_pkg;

  // command codes
  typedef enum logic [1:0] {
    OP_INS_FIRST = 2'd0,
    OP_INS_LAST  = 2'd1,
    OP_INS_AT    = 2'd2,
    OP_DEL_AT    = 2'd3
  } pidl_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } pidl_status_t;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int OUT_CNT_W = 7;
  localparam int GROUP_SZ = 8;

  // control broadcast to the cell row
  typedef struct packed {
    logic ins;  // open a gap at the target slot and load the new value
    logic del;  // close the gap at the target slot
  } pidl_cell_ctl_t;

endpackage

// File: hdl/pidl_cell.sv
// ----------------------------------------------------------------------------
// pidl_cell: one slot of the list
// Holds one element; on insert it takes its left neighbor, on delete its
// right neighbor, depending on where it sits relative to the target slot.
// ----------------------------------------------------------------------------
module pidl_cell
  import pidl_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CMP_W = 7
) (
  input  logic                     clk,
  input  pidl_cell_ctl_t           ctl,
  input  logic [CMP_W-1:0]         where,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic signed [DATA_W-1:0] tap
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // next element of this slot
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > where) begin
        data_nxt = left_data;
      end else if (MY_IDX == where) begin
        data_nxt = new_value;
      end
    end else if (ctl.del) begin
      if (MY_IDX >= where) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

  // readout of the target slot, zero elsewhere
  assign tap = (MY_IDX == where) ? data_r : '0;

endmodule

// File: hdl/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list: bounded ordered list of signed 32-bit values
// Insert at front, back or position, delete at position, over a cell row.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low; in_operation selects insert first, insert last, insert at
//   in_position or delete at in_position, in_value is the value to insert.
//   busy stays low: the row of cells shifts every element in the same cycle,
//   so a new command is taken every cycle.
//   Each command gives exactly one result transaction, shown for one cycle
//   with out_valid high and registered through stage 1, which captures the
//   selected slot ORed within groups of eight cells as the cells update, and
//   stage 2, which ORs the groups. Results keep command order.
//   out_status gives done, bad position or list full; out_removed_value holds
//   the value of a successful delete and zero otherwise; out_count is the
//   element count after the command (low 7 bits).
//   The receiver cannot stall the result channel.
//   Reset (rst_n low at a clock edge) empties the list and drops any result
//   still in flight; no clearing pass is needed.
// ----------------------------------------------------------------------------
module positional_insert_delete_list
  import pidl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_operation,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [OUT_CNT_W-1:0]     out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int NGRP  = (CAPACITY + GROUP_SZ - 1) / GROUP_SZ;

  // element count
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // command decode
  pidl_op_t         op;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] where;
  logic             is_ins;
  logic             bad_pos;
  logic             full;
  logic             accept;
  pidl_status_t     status;
  pidl_cell_ctl_t   ctl;
  logic [CMP_W-1:0] cnt_nxt_ext;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = pidl_op_t'(in_operation);
  assign cnt_ext = CMP_W'(cnt_r);

  always_comb begin
    case (op)
      OP_INS_FIRST: where = '0;
      OP_INS_LAST:  where = cnt_ext;
      default:      where = CMP_W'(in_position);
    endcase
  end

  always_comb begin
    is_ins  = (op != OP_DEL_AT);
    bad_pos = is_ins ? (where > cnt_ext) : (where >= cnt_ext);
    full    = is_ins && (cnt_r == CNT_W'(CAPACITY));
    if (bad_pos) begin
      status = ST_BAD_POS;
    end else if (full) begin
      status = ST_FULL;
    end else begin
      status = ST_DONE;
    end
    ctl.ins = accept && is_ins && !bad_pos && !full;
    ctl.del = accept && !is_ins && !bad_pos;
  end

  // count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.del) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end
  assign cnt_nxt_ext = CMP_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // row of cells
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic signed [DATA_W-1:0] cell_tap  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    pidl_cell #(
      .INDEX (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .where      (where),
      .new_value  (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // stage 1: group OR of the selected slot, status and count
  logic signed [DATA_W-1:0] grp_nxt [NGRP];
  logic signed [DATA_W-1:0] grp_r   [NGRP];
  logic                     s1_valid_r;
  logic [1:0]               s1_status_r;
  logic [OUT_CNT_W-1:0]     s1_count_r;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_SZ; k++) begin
        if (g * GROUP_SZ + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_tap[g * GROUP_SZ + k];
        end
      end
      if (!ctl.del) begin
        grp_nxt[g] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_status_r <= status;
    s1_count_r  <= cnt_nxt_ext[OUT_CNT_W-1:0];
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  // stage 2: final OR and result register
  logic signed [DATA_W-1:0] removed_nxt;
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_removed_r;
  logic [OUT_CNT_W-1:0]     out_count_r;

  always_comb begin
    removed_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      removed_nxt = removed_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= s1_status_r;
    out_removed_r <= removed_nxt;
    out_count_r   <= s1_count_r;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_count         = out_count_r;

endmodule

// File: verif/positional_insert_delete_list_tb.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list_tb: testbench of the positional list
// Commands go through the start/busy handshake. A shadow queue of the list
// predicts status, removed value and count for each command. Every result
// strobe is compared with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_insert_delete_list_tb;
  import pidl_pkg::*;

  localparam int LIST_CAP    = 64;
  localparam int MAX_CYCLES  = 200000;
  localparam int DRAIN_WAIT  = 6;
  localparam int WALK_PHASES = 16;
  localparam int PHASE_LEN   = 100;

  // expected result of one command
  typedef struct {
    pidl_status_t            status;
    logic signed [DATA_W-1:0] removed;
    logic [OUT_CNT_W-1:0]    count;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [1:0]               in_operation;
  logic [POS_W-1:0]         in_position;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_removed_value;
  logic [OUT_CNT_W-1:0]     out_count;

  // shadow of the list contents, front at index 0
  logic signed [DATA_W-1:0] shadow_list[$];
  list_result_t             pending_results[$];
  int                       err_cnt;
  int                       cycle_cnt;
  bit                       gaps_on;

  positional_insert_delete_list #(
    .CAPACITY(LIST_CAP)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_position      (in_position),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_count        (out_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // update the shadow list and work out the result of one command
  function automatic list_result_t predict_list_cmd(pidl_op_t op, logic [POS_W-1:0] pos,
                                                     logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           fill;
    int           where;
    fill      = shadow_list.size();
    r.status  = ST_DONE;
    r.removed = '0;
    if (op == OP_DEL_AT) begin
      if (int'(pos) >= fill) begin
        r.status = ST_BAD_POS;
      end else begin
        r.removed = shadow_list[pos];
        shadow_list.delete(pos);
      end
    end else begin
      case (op)
        OP_INS_FIRST: where = 0;
        OP_INS_LAST:  where = fill;
        default:      where = int'(pos);
      endcase
      // bad position wins over a full list
      if (where > fill) begin
        r.status = ST_BAD_POS;
      end else if (fill >= LIST_CAP) begin
        r.status = ST_FULL;
      end else begin
        shadow_list.insert(where, val);
      end
    end
    r.count = OUT_CNT_W'(shadow_list.size());
    return r;
  endfunction

  // drive one command transaction, record its prediction, then idle a random gap if gaps are on
  task automatic issue_cmd(pidl_op_t op, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    int unsigned gap;
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_list_cmd(op, pos, val));
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // value with extremes mixed in
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one random command, leaning toward growth or shrinkage
  task automatic random_cmd(bit grow);
    pidl_op_t         op;
    logic [POS_W-1:0] pos;
    int               fill;
    bit               do_insert;
    fill      = shadow_list.size();
    do_insert = ($urandom_range(0, 99) < 75) ? grow : !grow;
    if (do_insert) begin
      case ($urandom_range(0, 2))
        0:       op = OP_INS_FIRST;
        1:       op = OP_INS_LAST;
        default: op = OP_INS_AT;
      endcase
    end else begin
      op = OP_DEL_AT;
    end
    if ($urandom_range(0, 9) == 0 || op == OP_INS_FIRST || op == OP_INS_LAST) begin
      pos = POS_W'($urandom_range(0, 127));
    end else if (op == OP_INS_AT) begin
      pos = POS_W'($urandom_range(0, fill));
    end else begin
      pos = (fill == 0) ? '0 : POS_W'($urandom_range(0, fill - 1));
    end
    issue_cmd(op, pos, pick_value());
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction status=%0d removed=%0d count=%0d",
                 $time, out_status, out_removed_value, out_count);
        err_cnt = err_cnt + 1;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, exp_r.status, out_status);
          err_cnt = err_cnt + 1;
        end
        if (out_removed_value !== exp_r.removed) begin
          $display("%0t: removed_value mismatch, expected %0d, actual %0d",
                   $time, exp_r.removed, out_removed_value);
          err_cnt = err_cnt + 1;
        end
        if (out_count !== exp_r.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d",
                   $time, exp_r.count, out_count);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  // faults on an empty list
  task automatic test_empty_faults();
    issue_cmd(OP_DEL_AT, 7'd0, 32'sd5);
    issue_cmd(OP_DEL_AT, 7'd127, '1);
    issue_cmd(OP_INS_AT, 7'd1, 32'sd9);
    issue_cmd(OP_INS_AT, 7'd127, 32'sh8000_0000);
  endtask

  // every operation with extreme values, front, middle and back
  task automatic test_basic_ops();
    issue_cmd(OP_INS_FIRST, 7'd127, 32'sh7fff_ffff);
    issue_cmd(OP_INS_LAST, 7'd64, 32'sh8000_0000);
    issue_cmd(OP_INS_FIRST, 7'd0, '1);
    issue_cmd(OP_INS_LAST, 7'd0, '0);
    issue_cmd(OP_INS_AT, 7'd2, 32'sh5555_aaaa);
    issue_cmd(OP_INS_AT, 7'd0, 32'sh2aaa_5555);
    issue_cmd(OP_INS_AT, 7'd6, 32'sh1234_5678);
    issue_cmd(OP_INS_AT, 7'd8, 32'sd1);
    issue_cmd(OP_DEL_AT, 7'd7, '0);
    issue_cmd(OP_DEL_AT, 7'd3, '1);
    issue_cmd(OP_DEL_AT, 7'd5, '0);
    issue_cmd(OP_DEL_AT, 7'd0, '0);
    issue_cmd(OP_DEL_AT, 7'd64, '0);
    while (shadow_list.size() > 0) issue_cmd(OP_DEL_AT, 7'd0, '1);
  endtask

  // fill to capacity, hit the full cases, then drain at random positions
  task automatic test_fill_and_drain();
    while (shadow_list.size() < LIST_CAP) random_cmd(1'b1);
    issue_cmd(OP_INS_FIRST, 7'd0, pick_value());
    issue_cmd(OP_INS_LAST, 7'd127, pick_value());
    issue_cmd(OP_INS_AT, 7'd64, pick_value());
    issue_cmd(OP_INS_AT, 7'd0, pick_value());
    // bad position and full together
    issue_cmd(OP_INS_AT, 7'd65, pick_value());
    issue_cmd(OP_INS_AT, 7'd127, pick_value());
    issue_cmd(OP_DEL_AT, 7'd64, '0);
    issue_cmd(OP_DEL_AT, 7'd63, '0);
    issue_cmd(OP_INS_AT, 7'd63, pick_value());
    while (shadow_list.size() > 0) begin
      issue_cmd(OP_DEL_AT, POS_W'($urandom_range(0, shadow_list.size() - 1)), pick_value());
    end
    issue_cmd(OP_DEL_AT, 7'd0, '0);
  endtask

  // random walk of the fill level, with and without idle gaps
  task automatic test_random_walk();
    bit grow;
    grow = 1'b1;
    for (int ph = 0; ph < WALK_PHASES; ph++) begin
      gaps_on = ph[0];
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (shadow_list.size() >= LIST_CAP) grow = 1'b0;
        else if (shadow_list.size() == 0) grow = 1'b1;
        else if ($urandom_range(0, 39) == 0) grow = !grow;
        random_cmd(grow);
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_INS_FIRST;
    in_position  = '0;
    in_value     = '0;
    err_cnt      = 0;
    cycle_cnt    = 0;
    gaps_on      = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_faults();
    test_basic_ops();
    gaps_on = 1'b0;
    test_fill_and_drain();
    gaps_on = 1'b1;
    test_random_walk();

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: positional_insert_delete_list.f
hdl/pidl_pkg.sv
hdl/pidl_cell.sv
hdl/positional_insert_delete_list.sv
verif/positional_insert_delete_list_tb.sv
